FILE: sv/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the motorized step controller.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int DEFAULT_TIMER_WIDTH = 16;
    localparam int CFG_WIDTH           = 16;
    localparam int CFG_INDEX_WIDTH     = 2;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET  = 16'd10000;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT  = 2'd1;

    typedef enum logic [2:0] {
        PS_INIT         = 3'd0,
        PS_CLOSED       = 3'd1,
        PS_OPEN         = 3'd2,
        PS_OPENING      = 3'd3,
        PS_CLOSING      = 3'd4,
        PS_AUTO_CLOSING = 3'd5,
        PS_ERROR        = 3'd6,
        PS_STANDALONE   = 3'd7
    } pos_t;

    typedef enum logic [1:0] {
        DRV_OFF   = 2'd0,
        DRV_OPEN  = 2'd1,
        DRV_CLOSE = 2'd2
    } drive_t;

    typedef enum logic [2:0] {
        FN_TICK        = 3'd0,
        FN_COMMAND     = 3'd1,
        FN_KEY_ON      = 3'd2,
        FN_LINK_LOST   = 3'd3,
        FN_LINK_REGAIN = 3'd4,
        FN_REG_ACK     = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ACT_OPEN   = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_OTHER  = 2'd3
    } action_t;

    typedef struct packed {
        func_t   func;
        action_t action;
        logic    closed_switch;
        logic    open_switch;
        logic    key_active;
    } item_t;

    // control part of the block state; the tick counters travel separately
    typedef struct packed {
        pos_t   pos;
        logic   link_lost;
        logic   closed_prev;
        logic   open_prev;
        drive_t dir;
    } ctrl_t;

    typedef struct packed {
        drive_t motor_drive;
        pos_t   reported_state;
        logic   timeout_error;
        logic   status_request;
        logic   open_notice;
        logic   open_notice_key;
    } result_t;

endpackage

FILE: sv/msc_step.sv
// ----------------------------------------------------------------------------
// msc_step
// Next-state and result logic for one tick or event.
// ----------------------------------------------------------------------------
module msc_step #(
    parameter int TIMER_WIDTH = msc_pkg::DEFAULT_TIMER_WIDTH
) (
    input  msc_pkg::item_t                  item,
    input  msc_pkg::ctrl_t                  st,
    input  logic [TIMER_WIDTH-1:0]          db_elapsed,
    input  logic [TIMER_WIDTH-1:0]          run_elapsed,
    input  logic [msc_pkg::CFG_WIDTH-1:0]   debounce_ticks,
    input  logic [msc_pkg::CFG_WIDTH-1:0]   motor_timeout_ticks,
    output msc_pkg::ctrl_t                  st_next,
    output logic [TIMER_WIDTH-1:0]          db_next,
    output logic [TIMER_WIDTH-1:0]          run_next,
    output msc_pkg::result_t                res
);

    localparam int CMP_W = (TIMER_WIDTH > msc_pkg::CFG_WIDTH) ? TIMER_WIDTH
                                                               : msc_pkg::CFG_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TMR_MAX = {TIMER_WIDTH{1'b1}};

    always_comb
    begin
        msc_pkg::ctrl_t         s;
        logic [TIMER_WIDTH-1:0] db;
        logic [TIMER_WIDTH-1:0] run;
        logic                   status;
        logic                   notice;

        s      = st;
        db     = db_elapsed;
        run    = run_elapsed;
        status = 1'b0;
        notice = 1'b0;

        case (item.func)
            msc_pkg::FN_TICK:
            begin
                if (s.pos == msc_pkg::PS_INIT)
                begin
                    s.pos = item.closed_switch ? msc_pkg::PS_CLOSED : msc_pkg::PS_OPEN;
                end
                db = (db == TMR_MAX) ? db : db + 1'b1;
                // one debounce interval shared by both switches
                if (item.closed_switch && !s.closed_prev &&
                    (CMP_W'(db) > CMP_W'(debounce_ticks)))
                begin
                    db = '0;
                    if (s.pos == msc_pkg::PS_CLOSING || s.pos == msc_pkg::PS_AUTO_CLOSING)
                    begin
                        s.dir  = msc_pkg::DRV_OFF;
                        s.pos  = msc_pkg::PS_CLOSED;
                        status = 1'b1;
                    end
                end
                if (item.open_switch && !s.open_prev &&
                    (CMP_W'(db) > CMP_W'(debounce_ticks)))
                begin
                    db = '0;
                    if (s.pos == msc_pkg::PS_OPENING)
                    begin
                        s.dir  = msc_pkg::DRV_OFF;
                        s.pos  = msc_pkg::PS_OPEN;
                        status = 1'b1;
                        notice = !s.link_lost;
                    end
                end
                s.closed_prev = item.closed_switch;
                s.open_prev   = item.open_switch;
                if (s.dir != msc_pkg::DRV_OFF)
                begin
                    run = (run == TMR_MAX) ? run : run + 1'b1;
                    if (CMP_W'(run) > CMP_W'(motor_timeout_ticks))
                    begin
                        s.dir  = msc_pkg::DRV_OFF;
                        s.pos  = msc_pkg::PS_ERROR;
                        status = 1'b1;
                    end
                end
            end
            msc_pkg::FN_COMMAND:
            begin
                // key on blocks everything but a status query
                if (!item.key_active || item.action == msc_pkg::ACT_STATUS)
                begin
                    if (item.action == msc_pkg::ACT_OPEN && s.pos == msc_pkg::PS_CLOSED)
                    begin
                        s.dir  = msc_pkg::DRV_OPEN;
                        run    = '0;
                        s.pos  = msc_pkg::PS_OPENING;
                        status = 1'b1;
                    end
                    else if (item.action == msc_pkg::ACT_CLOSE && s.pos == msc_pkg::PS_OPEN)
                    begin
                        s.dir  = msc_pkg::DRV_CLOSE;
                        run    = '0;
                        s.pos  = msc_pkg::PS_CLOSING;
                        status = 1'b1;
                    end
                    else if (item.action == msc_pkg::ACT_STATUS)
                    begin
                        status = 1'b1;
                    end
                end
            end
            msc_pkg::FN_KEY_ON:
            begin
                if (s.pos == msc_pkg::PS_OPEN || s.pos == msc_pkg::PS_OPENING)
                begin
                    s.dir  = msc_pkg::DRV_CLOSE;
                    run    = '0;
                    s.pos  = msc_pkg::PS_AUTO_CLOSING;
                    status = 1'b1;
                end
            end
            msc_pkg::FN_LINK_LOST:
            begin
                if (!s.link_lost)
                begin
                    s.link_lost = 1'b1;
                    status      = 1'b1;
                end
            end
            msc_pkg::FN_LINK_REGAIN:
            begin
                if (s.link_lost)
                begin
                    s.link_lost = 1'b0;
                    status      = 1'b1;
                    notice      = (s.pos == msc_pkg::PS_OPEN);
                end
            end
            msc_pkg::FN_REG_ACK:
            begin
                status = 1'b1;
                notice = (s.pos == msc_pkg::PS_OPEN) && !s.link_lost;
            end
            default:
            begin
            end
        endcase

        st_next  = s;
        db_next  = db;
        run_next = run;

        res.motor_drive     = s.dir;
        res.reported_state  = s.link_lost ? msc_pkg::PS_STANDALONE : s.pos;
        res.timeout_error   = (s.pos == msc_pkg::PS_ERROR);
        res.status_request  = status;
        res.open_notice     = notice;
        res.open_notice_key = notice && item.key_active;
    end

endmodule

FILE: sv/motorized_step_controller_unit.sv
// ----------------------------------------------------------------------------
// motorized_step_controller_unit
// Motorized step controller: end switch debounce, motor run and timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one tick or event per
//   transfer; output channel (out_valid / out_stall) returns exactly one
//   result per input transfer, in order.
//   Each item passes through the input register and then, through the state
//   update, into the result register, which raises out_valid.
//   Throughput is one item per cycle while out_stall is low; the state
//   update is a single combinational pass, so back-to-back items follow
//   each other.
//   When out_stall is held the result register keeps its item, the input
//   register can still take one more, and only then is in_stall raised.
//   Configuration writes (cfg_valid / cfg_ready, always ready) set the
//   debounce interval and motor timeout; unknown indices are ignored.
//   Reset puts the step in the init state with the motor off, the link up,
//   counters cleared and both registers at their reset values; the first
//   tick takes the position from the closed switch.
// ----------------------------------------------------------------------------
module motorized_step_controller_unit #(
    parameter int TIMER_WIDTH = msc_pkg::DEFAULT_TIMER_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          func,
    input  logic [1:0]                          action,
    input  logic                                closed_switch,
    input  logic                                open_switch,
    input  logic                                key_active,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          motor_drive,
    output logic [2:0]                          reported_state,
    output logic                                timeout_error,
    output logic                                status_request,
    output logic                                open_notice,
    output logic                                open_notice_key,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [msc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [msc_pkg::CFG_WIDTH-1:0]       cfg_data
);

    logic                            in_valid_reg;
    msc_pkg::item_t                  in_item_reg;
    logic                            out_valid_reg;
    msc_pkg::result_t                out_res_reg;

    msc_pkg::ctrl_t                  ctrl_reg;
    logic [TIMER_WIDTH-1:0]          db_reg;
    logic [TIMER_WIDTH-1:0]          run_reg;
    logic [msc_pkg::CFG_WIDTH-1:0]   debounce_reg;
    logic [msc_pkg::CFG_WIDTH-1:0]   timeout_reg;

    msc_pkg::ctrl_t                  ctrl_next;
    logic [TIMER_WIDTH-1:0]          db_next;
    logic [TIMER_WIDTH-1:0]          run_next;
    msc_pkg::result_t                res_next;
    msc_pkg::item_t                  in_item;

    logic                            out_load;
    logic                            in_take;
    logic                            step_fire;

    // result register frees up when empty or being taken
    assign out_load  = !out_valid_reg || !out_stall;
    assign step_fire = in_valid_reg && out_load;
    assign in_stall  = in_valid_reg && !out_load;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_item.func          = msc_pkg::func_t'(func);
    assign in_item.action        = msc_pkg::action_t'(action);
    assign in_item.closed_switch = closed_switch;
    assign in_item.open_switch   = open_switch;
    assign in_item.key_active    = key_active;

    msc_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .item                (in_item_reg),
        .st                  (ctrl_reg),
        .db_elapsed          (db_reg),
        .run_elapsed         (run_reg),
        .debounce_ticks      (debounce_reg),
        .motor_timeout_ticks (timeout_reg),
        .st_next             (ctrl_next),
        .db_next             (db_next),
        .run_next            (run_next),
        .res                 (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            ctrl_reg.pos          <= msc_pkg::PS_INIT;
            ctrl_reg.link_lost    <= 1'b0;
            ctrl_reg.closed_prev  <= 1'b0;
            ctrl_reg.open_prev    <= 1'b0;
            ctrl_reg.dir          <= msc_pkg::DRV_OFF;
            db_reg                <= '0;
            run_reg               <= '0;
            debounce_reg          <= msc_pkg::DEBOUNCE_RESET;
            timeout_reg           <= msc_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step_fire)
            begin
                ctrl_reg <= ctrl_next;
                db_reg   <= db_next;
                run_reg  <= run_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    msc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                    msc_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (step_fire)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign motor_drive     = out_res_reg.motor_drive;
    assign reported_state  = out_res_reg.reported_state;
    assign timeout_error   = out_res_reg.timeout_error;
    assign status_request  = out_res_reg.status_request;
    assign open_notice     = out_res_reg.open_notice;
    assign open_notice_key = out_res_reg.open_notice_key;

    // a notice only ever goes out with the open state shown
    a_notice_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && open_notice |-> reported_state == msc_pkg::PS_OPEN)
        else $error("open notice without open state");

    a_notice_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && open_notice_key |-> open_notice)
        else $error("notice key flag without notice");

    a_error_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timeout_error |-> motor_drive == msc_pkg::DRV_OFF)
        else $error("motor driven in error state");

    // a waiting input item is not dropped while the result side is blocked
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending input item lost");

endmodule
